FILE: hw/rtl/afb_pkg.sv
// Shared types, constants and helpers for the activation forward/backward block.
package afb_pkg;

	localparam int DATA_W = 16;
	localparam int IDX_W  = 6;
	localparam int CNT_W  = 11;
	localparam int WIDE_W = 48;

	typedef enum logic [1:0] {
		MODE_LINEAR,
		MODE_RELU,
		MODE_TANH,
		MODE_SOFTMAX
	} mode_t;

	localparam logic OP_FWD = 1'b0;
	localparam logic OP_BWD = 1'b1;

	localparam logic CFG_MODE    = 1'b0;
	localparam logic CFG_ROW_LEN = 1'b1;

	typedef struct packed {
		logic               op;
		logic signed [15:0] in_value;
		logic signed [15:0] in_grad;
	} item_t;

	typedef struct packed {
		logic signed [15:0] result;
		logic [IDX_W-1:0]   index;
		logic               last;
	} res_t;

	typedef struct packed {
		logic               bank;
		logic [CNT_W-1:0]   cnt;
		logic               op;
		logic signed [15:0] max;
		mode_t              mode;
	} desc_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_LOAD,
		S_EXP_A,
		S_EXP_B,
		S_ACC,
		S_DIV_SET,
		S_DIV,
		S_QUOT,
		S_MUL_A,
		S_MUL_B,
		S_EMIT
	} back_state_t;

	// 2^(-k/16) in Q1.16
	function automatic logic [16:0] pow2_tab(input logic [4:0] k);
		logic [16:0] v;
		case (k)
			5'd0:  v = 17'd65536;
			5'd1:  v = 17'd62757;
			5'd2:  v = 17'd60097;
			5'd3:  v = 17'd57549;
			5'd4:  v = 17'd55109;
			5'd5:  v = 17'd52773;
			5'd6:  v = 17'd50535;
			5'd7:  v = 17'd48393;
			5'd8:  v = 17'd46341;
			5'd9:  v = 17'd44376;
			5'd10: v = 17'd42495;
			5'd11: v = 17'd40693;
			5'd12: v = 17'd38968;
			5'd13: v = 17'd37316;
			5'd14: v = 17'd35734;
			5'd15: v = 17'd34219;
			5'd16: v = 17'd32768;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE_W-1:0] x);
		logic signed [DATA_W-1:0] r;
		if (x > WIDE_W'(32767))
			r = 16'sh7fff;
		else if (x < -WIDE_W'(32768))
			r = 16'sh8000;
		else
			r = x[DATA_W-1:0];
		return r;
	endfunction

endpackage

FILE: hw/rtl/afb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module afb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/afb_front.sv
// Row loader: stores elements into a bank, tracks the maximum, queues finished rows.
module afb_front
	import afb_pkg::*;
#(
	parameter int MAX_ROW = 64,
	localparam int CW = $clog2(MAX_ROW + 1),
	localparam int IW = $clog2(MAX_ROW),
	localparam int AW = IW + 1,
	localparam int LW = (CW > 7) ? CW : 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  item_t                    item,
	input  mode_t                    mode,
	input  logic [6:0]               row_len,
	output logic                     ram_we,
	output logic [AW-1:0]            ram_waddr,
	output logic signed [DATA_W-1:0] ram_wv,
	output logic signed [DATA_W-1:0] ram_wg,
	output desc_t                    desc,
	output logic                     desc_valid,
	input  logic                     desc_pop
);

	logic [CW-1:0]            fill_q;
	logic                     bank_q;
	logic                     op_q;
	logic signed [DATA_W-1:0] max_q;
	desc_t                    dq_q [2];
	logic                     wr_ptr_q;
	logic                     rd_ptr_q;
	logic [1:0]               cnt_q;

	logic [LW-1:0]            rl_ext;
	logic [CW-1:0]            len;
	logic                     accept;
	logic                     done;
	logic                     row_op;
	logic signed [DATA_W-1:0] new_max;

	assign rl_ext = LW'(row_len);

	always_comb begin
		if (rl_ext == '0)
			len = CW'(1);
		else if (rl_ext > LW'(MAX_ROW))
			len = CW'(MAX_ROW);
		else
			len = CW'(rl_ext);
	end

	assign full       = (cnt_q == 2'd2);
	assign accept     = push && !full;
	assign done       = ((fill_q + CW'(1)) >= len);
	assign row_op     = (fill_q == '0) ? item.op : op_q;
	assign new_max    = (fill_q == '0 || item.in_value > max_q) ? item.in_value : max_q;
	assign ram_we     = accept;
	assign ram_waddr  = {bank_q, fill_q[IW-1:0]};
	assign ram_wv     = item.in_value;
	assign ram_wg     = item.in_grad;
	assign desc       = dq_q[rd_ptr_q];
	assign desc_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			bank_q   <= 1'b0;
			op_q     <= OP_FWD;
			max_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept) begin
				op_q  <= row_op;
				max_q <= new_max;
				if (done) begin
					fill_q   <= '0;
					bank_q   <= !bank_q;
					wr_ptr_q <= !wr_ptr_q;
				end else begin
					fill_q <= fill_q + CW'(1);
				end
			end
			if (desc_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, accept && done} - {1'b0, desc_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (accept && done) begin
			dq_q[wr_ptr_q] <= '{bank: bank_q, cnt: CNT_W'(fill_q) + CNT_W'(1), op: row_op,
				max: new_max, mode: mode};
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("row queue overflow");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CW'(MAX_ROW)) else $error("fill count out of range");
`endif

endmodule

FILE: hw/rtl/afb_back.sv
// Row engine: softmax reduction pass, per-element activation/gradient, divider, result register.
module afb_back
	import afb_pkg::*;
#(
	parameter int MAX_ROW = 64,
	localparam int CW = $clog2(MAX_ROW + 1),
	localparam int IW = $clog2(MAX_ROW),
	localparam int AW = IW + 1,
	localparam int ACC_W = 34 + $clog2(MAX_ROW)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  desc_t                    desc,
	input  logic                     desc_valid,
	output logic                     desc_pop,
	output logic [AW-1:0]            ram_raddr,
	input  logic signed [DATA_W-1:0] ram_rv,
	input  logic signed [DATA_W-1:0] ram_rg,
	output res_t                     res,
	output logic                     empty,
	input  logic                     pop
);

	back_state_t              state_q, state_d;
	desc_t                    d_q;
	logic                     pass_q;
	logic [CW-1:0]            idx_q;
	logic                     mstep_q;
	logic signed [DATA_W-1:0] g_q, res_q;
	logic [16:0]              arg_q, t_q, e_q;
	logic                     neg_q;
	logic signed [16:0]       mul_a_q;
	logic signed [24:0]       mul_b_q;
	logic signed [41:0]       p_q;
	logic [ACC_W-1:0]         rem_q, den_q;
	logic [8:0]               quo_q;
	logic [3:0]               bit_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     out_valid_q;
	res_t                     out_q;

	logic                     last_el;
	logic                     emit_go;
	logic signed [DATA_W-1:0] dsm;
	logic signed [DATA_W-1:0] gmd;
	logic [25:0]              tprod;
	logic [16:0]              tk, tk1, corr, m;
	logic [20:0]              cprod;
	logic [16:0]              e_next;
	logic signed [24:0]       w_val;
	logic signed [DATA_W-1:0] p_rnd;
	logic signed [ACC_W-1:0]  addend;
	logic [ACC_W-1:0]         den_sh;
	logic [16:0]              absv2;
	logic signed [16:0]       sdiff;

	assign last_el = (idx_q == CW'(d_q.cnt - CNT_W'(1)));
	assign emit_go = !out_valid_q || pop;
	assign empty   = !out_valid_q;
	assign res     = out_q;

	assign dsm   = sat_data((WIDE_W'(acc_q) + 48'sd128) >>> 8);
	assign gmd   = sat_data(WIDE_W'(ram_rg) - WIDE_W'(dsm));
	assign absv2 = ram_rv[DATA_W-1] ? 17'(-18'(ram_rv)) << 1 : 17'(ram_rv) << 1;
	assign sdiff = 17'(d_q.max) - 17'(ram_rv);

	assign tprod  = 26'(arg_q) * 26'd369;
	assign tk     = pow2_tab({1'b0, t_q[7:4]});
	assign tk1    = pow2_tab({1'b0, t_q[7:4]} + 5'd1);
	assign cprod  = 21'(tk - tk1) * 21'(t_q[3:0]);
	assign corr   = 17'((cprod + 21'd8) >> 4);
	assign m      = tk - corr;
	assign e_next = (t_q[16:8] > 9'd16) ? 17'd0 : (m >> t_q[12:8]);

	assign w_val  = 25'sd256 - 25'((WIDE_W'(p_q) + 48'sd128) >>> 8);
	assign p_rnd  = sat_data((WIDE_W'(p_q) + 48'sd128) >>> 8);
	assign addend = (d_q.op == OP_FWD) ? ACC_W'($signed({1'b0, e_q})) : ACC_W'(p_q);
	assign den_sh = den_q << bit_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (desc_valid) state_d = S_READ;
			S_READ:    state_d = S_LOAD;
			S_LOAD: begin
				case (d_q.mode)
					MODE_TANH, MODE_SOFTMAX:
						state_d = (d_q.op == OP_FWD) ? S_EXP_A : S_MUL_A;
					default: state_d = S_EMIT;
				endcase
			end
			S_EXP_A:   state_d = S_EXP_B;
			S_EXP_B:   state_d = (d_q.mode == MODE_SOFTMAX && !pass_q) ? S_ACC : S_DIV_SET;
			S_ACC:     state_d = S_READ;
			S_DIV_SET: state_d = S_DIV;
			S_DIV:     if (bit_q == 4'd0) state_d = S_QUOT;
			S_QUOT:    state_d = S_EMIT;
			S_MUL_A:   state_d = S_MUL_B;
			S_MUL_B: begin
				if (d_q.mode == MODE_TANH && !mstep_q)
					state_d = S_MUL_A;
				else if (d_q.mode == MODE_SOFTMAX && !pass_q)
					state_d = S_ACC;
				else
					state_d = S_EMIT;
			end
			S_EMIT:    if (emit_go) state_d = last_el ? S_IDLE : S_READ;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ram_raddr = {d_q.bank, idx_q[IW-1:0]};
		desc_pop  = (state_q == S_EMIT) && emit_go && last_el;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EMIT && emit_go)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				d_q    <= desc;
				pass_q <= (desc.mode != MODE_SOFTMAX);
				acc_q  <= '0;
				idx_q  <= '0;
			end
			S_LOAD: begin
				g_q     <= ram_rg;
				mstep_q <= 1'b0;
				neg_q   <= ram_rv[DATA_W-1];
				arg_q   <= (d_q.mode == MODE_TANH) ? absv2 : 17'(sdiff);
				mul_a_q <= 17'(ram_rv);
				mul_b_q <= (d_q.mode == MODE_TANH) ? 25'(ram_rv)
					: (pass_q ? 25'(gmd) : 25'(ram_rg));
				case (d_q.mode)
					MODE_RELU: begin
						if (d_q.op == OP_FWD)
							res_q <= (ram_rv > 0) ? ram_rv : '0;
						else
							res_q <= (ram_rv > 0) ? ram_rg : '0;
					end
					default: res_q <= (d_q.op == OP_FWD) ? ram_rv : ram_rg;
				endcase
			end
			S_EXP_A: t_q <= 17'((tprod + 26'd128) >> 8);
			S_EXP_B: e_q <= e_next;
			S_ACC: begin
				acc_q <= acc_q + addend;
				if (last_el) begin
					pass_q <= 1'b1;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			S_DIV_SET: begin
				quo_q <= '0;
				bit_q <= 4'd8;
				if (d_q.mode == MODE_TANH) begin
					den_q <= ACC_W'(18'd65536 + 18'(e_q));
					rem_q <= (ACC_W'(18'd65536 - 18'(e_q)) << 8)
						+ (ACC_W'(18'd65536 + 18'(e_q)) >> 1);
				end else begin
					den_q <= ACC_W'(acc_q);
					rem_q <= (ACC_W'(e_q) << 8) + (ACC_W'(acc_q) >> 1);
				end
			end
			S_DIV: begin
				if (rem_q >= den_sh) begin
					rem_q        <= rem_q - den_sh;
					quo_q[bit_q] <= 1'b1;
				end
				bit_q <= bit_q - 4'd1;
			end
			S_QUOT: begin
				if (d_q.mode == MODE_TANH && neg_q)
					res_q <= -DATA_W'(quo_q);
				else
					res_q <= DATA_W'(quo_q);
			end
			S_MUL_A: p_q <= 42'(mul_a_q * mul_b_q);
			S_MUL_B: begin
				mstep_q <= 1'b1;
				mul_a_q <= 17'(g_q);
				mul_b_q <= w_val;
				res_q   <= p_rnd;
			end
			S_EMIT: begin
				if (emit_go) begin
					out_q <= '{result: res_q, index: IDX_W'(idx_q), last: last_el};
					idx_q <= idx_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_busy_has_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> desc_valid) else $error("engine busy without a queued row");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> den_q != '0) else $error("divide by zero");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		desc_pop |-> desc_valid) else $error("row queue underflow");
`endif

endmodule

FILE: hw/rtl/activation_forward_backward.sv
// Top level: activation layer, forward and backward, row by row in Q8.8.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------
//  input   | push / full          | item (op, in_value, in_grad)
//  result  | pop / empty          | res (result, index, last)
//  config  | cfg_we (no wait)     | cfg_idx, cfg_data
//
// Elements load one per cycle, while full is low, into one of two row banks;
// the next row fills while the engine works on the previous one. Once it picks
// up a row, the engine reads and loads each element, then emits it directly
// (linear, relu), after one multiply (backward softmax), after two (backward
// tanh) or after the exponent and a 9-step divider (forward tanh/softmax);
// softmax first runs a reduction pass over the row. full rises when both banks
// hold rows; a stalled result stalls the engine. Reset is asynchronous.
module activation_forward_backward
	import afb_pkg::*;
#(
	parameter int MAX_ROW = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  item_t      item,
	output logic       empty,
	input  logic       pop,
	output res_t       res,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [6:0] cfg_data
);

	localparam int AW = $clog2(MAX_ROW) + 1;

	mode_t                    mode_q;
	logic [6:0]               row_len_q;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr, ram_raddr;
	logic signed [DATA_W-1:0] ram_wv, ram_wg, ram_rv, ram_rg;
	desc_t                    desc;
	logic                     desc_valid, desc_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_LINEAR;
			row_len_q <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MODE:    mode_q    <= mode_t'(cfg_data[1:0]);
				CFG_ROW_LEN: row_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	afb_front #(.MAX_ROW(MAX_ROW)) u_front (
		.clk, .arst_n, .push, .full, .item,
		.mode(mode_q), .row_len(row_len_q),
		.ram_we, .ram_waddr, .ram_wv, .ram_wg,
		.desc, .desc_valid, .desc_pop
	);

	afb_ram #(.WIDTH(DATA_W), .DEPTH(2 ** AW)) u_value_ram (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wv),
		.raddr(ram_raddr), .rdata(ram_rv)
	);

	afb_ram #(.WIDTH(DATA_W), .DEPTH(2 ** AW)) u_grad_ram (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wg),
		.raddr(ram_raddr), .rdata(ram_rg)
	);

	afb_back #(.MAX_ROW(MAX_ROW)) u_back (
		.clk, .arst_n, .desc, .desc_valid, .desc_pop,
		.ram_raddr, .ram_rv, .ram_rg, .res, .empty, .pop
	);

endmodule

FILE: sim/tb_activation_forward_backward.sv
// Testbench for activation_forward_backward: a row-level predictor checks each result transfer.
`timescale 1ns / 100ps

module tb_activation_forward_backward;
	import afb_pkg::*;

	localparam int ROW_MAX    = 64;
	localparam int IDLE_LIMIT = 20000;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	item_t      item;
	logic       empty;
	logic       pop;
	res_t       res;
	logic       cfg_we;
	logic       cfg_idx;
	logic [6:0] cfg_data;

	activation_forward_backward dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// 2^(-k/16) in Q1.16
	int unsigned frac_pow2 [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
		46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

	// predictor state
	mode_t      act_mode;
	logic [6:0] row_len_reg;
	longint     row_vals [ROW_MAX];
	longint     row_grads [ROW_MAX];
	int         row_fill;
	logic       row_dir;
	longint     row_peak;

	res_t expected_rows [$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;
	int mismatches;
	int items_sent;
	int rows_done;
	int results_seen;
	int full_stalls;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint round_shr8(input longint p);
		if (p >= 0)
			return (p + 128) >>> 8;
		return -((-p + 127) >>> 8);
	endfunction

	function automatic longint exp_neg(input longint a);
		longint t;
		longint n;
		longint m;
		int     k;
		int     r;
		t = (a * 369 + 128) >>> 8;
		n = t >>> 8;
		k = int'((t & 255) >> 4);
		r = int'(t & 15);
		if (n > 16)
			return 0;
		m = longint'(frac_pow2[k]) -
			(((longint'(frac_pow2[k]) - longint'(frac_pow2[k+1])) * r + 8) >>> 4);
		return m >>> n;
	endfunction

	function automatic logic signed [15:0] clamp_q88(input longint x);
		if (x > 32767)
			return 16'sh7fff;
		if (x < -32768)
			return 16'sh8000;
		return x[15:0];
	endfunction

	function automatic longint activate(input int i, input longint acc);
		longint v;
		longint g;
		longint a;
		longint e;
		longint den;
		longint q;
		longint w;
		longint d;
		v = row_vals[i];
		g = row_grads[i];
		if (row_dir == OP_FWD) begin
			case (act_mode)
				MODE_RELU: return v > 0 ? v : 0;
				MODE_TANH: begin
					a = v < 0 ? -v : v;
					e = exp_neg(2 * a);
					den = 65536 + e;
					q = ((65536 - e) * 256 + den / 2) / den;
					return v < 0 ? -q : q;
				end
				MODE_SOFTMAX: begin
					e = exp_neg(row_peak - v);
					return (e * 256 + acc / 2) / acc;
				end
				default: return v;
			endcase
		end
		case (act_mode)
			MODE_RELU: return v > 0 ? g : 0;
			MODE_TANH: begin
				w = 256 - round_shr8(v * v);
				if (w > (longint'(1) << 30)) w = longint'(1) << 30;
				if (w < -(longint'(1) << 30)) w = -(longint'(1) << 30);
				return round_shr8(g * w);
			end
			MODE_SOFTMAX: begin
				d = clamp_q88(round_shr8(acc));
				d = clamp_q88(g - d);
				return round_shr8(v * d);
			end
			default: return g;
		endcase
	endfunction

	task automatic predict_row(input item_t it);
		int     len;
		longint acc;
		res_t   r;
		len = row_len_reg == 0 ? 1 : (row_len_reg > ROW_MAX ? ROW_MAX : int'(row_len_reg));
		if (row_fill == 0) begin
			row_dir = it.op;
			row_peak = it.in_value;
		end else if (it.in_value > row_peak) begin
			row_peak = it.in_value;
		end
		row_vals[row_fill] = it.in_value;
		row_grads[row_fill] = it.in_grad;
		row_fill++;
		if (row_fill < len)
			return;
		acc = 0;
		if (act_mode == MODE_SOFTMAX)
			for (int i = 0; i < row_fill; i++)
				if (row_dir == OP_FWD)
					acc += exp_neg(row_peak - row_vals[i]);
				else
					acc += row_vals[i] * row_grads[i];
		for (int i = 0; i < row_fill; i++) begin
			r.result = clamp_q88(activate(i, acc));
			r.index = i[5:0];
			r.last = (i == row_fill - 1);
			expected_rows.push_back(r);
		end
		row_fill = 0;
		rows_done++;
	endtask

	task automatic send_elem(input logic op, input logic signed [15:0] v,
			input logic signed [15:0] g);
		item_t it;
		it.op = op;
		it.in_value = v;
		it.in_grad = g;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) begin
			full_stalls++;
			@(posedge clk);
		end
		predict_row(it);
		items_sent++;
	endtask

	task automatic drain;
		push <= 1'b0;
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] d);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MODE)
			act_mode = mode_t'(d[1:0]);
		else
			row_len_reg = d;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_value(input int style);
		case (style)
			0: return 16'($urandom);
			1: return 16'($urandom_range(1536)) - 16'sd768;
			default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	task automatic test_directed;
		drain;
		write_reg(CFG_ROW_LEN, 7'd1);
		for (int m = 0; m < 4; m++)
			for (int o = 0; o < 2; o++) begin
				write_reg(CFG_MODE, 7'(m));
				drain;
				send_elem(o[0], ((m + o) % 2) ? 16'sh7fff : 16'sh8000,
					((m + o) % 2) ? 16'sh8000 : 16'sh7fff);
				drain;
			end
		// relu at exactly zero, both directions
		write_reg(CFG_MODE, 7'(MODE_RELU));
		send_elem(OP_FWD, 16'sd0, 16'sh1234);
		send_elem(OP_BWD, 16'sd0, 16'sh7fff);
		drain;
		// zero row length behaves as one
		write_reg(CFG_ROW_LEN, 7'd0);
		send_elem(OP_BWD, 16'sh0080, 16'shff00);
		drain;
		// softmax of a row holding both extremes
		write_reg(CFG_ROW_LEN, 7'd2);
		write_reg(CFG_MODE, 7'(MODE_SOFTMAX));
		send_elem(OP_FWD, 16'sh7fff, 16'sd0);
		send_elem(OP_BWD, 16'sh8000, 16'sd0);
		drain;
		// mode switched while a row is partly loaded
		write_reg(CFG_ROW_LEN, 7'd3);
		send_elem(OP_FWD, 16'sh0100, 16'sd0);
		send_elem(OP_FWD, 16'shff00, 16'sd0);
		drain;
		write_reg(CFG_MODE, 7'(MODE_TANH));
		send_elem(OP_FWD, 16'sh0040, 16'sd0);
		drain;
		// row length cut below the stored count
		write_reg(CFG_ROW_LEN, 7'd4);
		send_elem(OP_BWD, 16'sh0080, 16'sh0100);
		send_elem(OP_BWD, 16'shff80, 16'sh0200);
		send_elem(OP_BWD, 16'sh00c0, 16'shfe00);
		drain;
		write_reg(CFG_ROW_LEN, 7'd2);
		send_elem(OP_BWD, 16'sh0010, 16'sh0300);
		drain;
	endtask

	task automatic test_random(input int snd_pct, input int rcv_pct, input int n_items);
		int   start;
		int   sel;
		int   style;
		logic op;
		start = items_sent;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		while (items_sent - start < n_items) begin
			drain;
			write_reg(CFG_MODE, 7'($urandom_range(3)));
			sel = $urandom_range(11);
			if (sel == 0)
				write_reg(CFG_ROW_LEN, $urandom_range(1) ? 7'd64 : 7'($urandom_range(65, 127)));
			else
				write_reg(CFG_ROW_LEN, 7'($urandom_range(1, 8)));
			repeat ($urandom_range(1, 4)) begin
				op = $urandom_range(1);
				style = $urandom_range(2);
				for (int i = 0; i < (row_len_reg == 0 ? 1 : row_len_reg); i++) begin
					if (i >= ROW_MAX)
						break;
					send_elem(i == 0 ? op : 1'($urandom), pick_value(style),
						pick_value($urandom_range(1) ? 0 : style));
				end
			end
		end
		drain;
	endtask

	task automatic test_backpressure;
		drain;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_MODE, 7'(MODE_LINEAR));
		write_reg(CFG_ROW_LEN, 7'd2);
		hold_cycles = 400;
		repeat (24)
			send_elem(1'($urandom), 16'($urandom), 16'($urandom));
		drain;
	endtask

	// result side: check each transfer, then decide pop for the next edge
	initial begin
		res_t want;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				results_seen++;
				if (expected_rows.size() == 0) begin
					$error("result with none expected: result=%0d index=%0d last=%0d",
						res.result, res.index, res.last);
					mismatches++;
				end else begin
					want = expected_rows.pop_front();
					if (res.result !== want.result) begin
						$error("result: expected %0d, got %0d", want.result, res.result);
						mismatches++;
					end
					if (res.index !== want.index) begin
						$error("index: expected %0d, got %0d", want.index, res.index);
						mismatches++;
					end
					if (res.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, res.last);
						mismatches++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		push = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_MODE;
		cfg_data = '0;
		arst_n = 1'b0;
		act_mode = MODE_LINEAR;
		row_len_reg = 7'd64;
		row_fill = 0;
		row_dir = OP_FWD;
		row_peak = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 0;
		mismatches = 0;
		items_sent = 0;
		rows_done = 0;
		results_seen = 0;
		full_stalls = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(26, 66, 64);
		test_random(66, 26, 64);
		test_random(0, 0, 64);
		test_backpressure();

		drain;
		repeat (50) @(posedge clk);
		if (expected_rows.size() != 0) begin
			$error("%0d expected results never arrived", expected_rows.size());
			mismatches++;
		end
		$display("tb: %0d elements in %0d rows, %0d results checked, all modes and directions",
			items_sent, rows_done, results_seen);
		$display("tb: %0d cycles with input held off by full, %0d mismatches",
			full_stalls, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: activation_forward_backward.f
hw/rtl/afb_pkg.sv
hw/rtl/afb_ram.sv
hw/rtl/afb_front.sv
hw/rtl/afb_back.sv
hw/rtl/activation_forward_backward.sv
sim/tb_activation_forward_backward.sv
